[sv/smt_pkg.sv]
// Package: shared constants and types for the split micro TLB.
package smt_pkg;
  localparam int unsigned Entries = 4;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned VaBits = 52;
  localparam int unsigned ValidBitPos = 15;
  localparam logic [63:0] VaMask = {64{1'b1}} >> (64 - VaBits);

  localparam logic [1:0] OP_ILOOKUP = 2'd0;
  localparam logic [1:0] OP_DLOOKUP = 2'd1;
  localparam logic [1:0] OP_PURGE   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] vaddr;
    logic        fill_valid;
    logic [63:0] fill_tag;
    logic [63:0] fill_phys;
    logic [63:0] fill_mask;
    logic [15:0] fill_info;
  } req_t;

  typedef struct packed {
    logic        translated;
    logic        local_hit;
    logic [63:0] phys_addr;
    logic [15:0] entry_info;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;
endpackage

[sv/smt_datapath.sv]
// Datapath: entry arrays, associative match, replacement and result register.
module smt_datapath import smt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output rsp_t rsp_o
);
  logic [63:0] itag_q [Entries], iphys_q [Entries], imask_q [Entries];
  logic [15:0] iinfo_q [Entries];
  logic [63:0] dtag_q [Entries], dphys_q [Entries], dmask_q [Entries];
  logic [15:0] dinfo_q [Entries];
  logic [IdxW-1:0] rptr_q;
  req_t req_q;
  rsp_t rsp_q;

  logic [Entries-1:0] ihit, dhit, ipm, dpm;
  logic [63:0] cva;
  assign cva = req_q.vaddr & VaMask;

  always_comb begin
    for (int k = 0; k < Entries; k++) begin
      ihit[k] = iinfo_q[k][ValidBitPos] && ((cva & imask_q[k]) == itag_q[k]);
      dhit[k] = dinfo_q[k][ValidBitPos] && ((cva & dmask_q[k]) == dtag_q[k]);
      ipm[k] = iinfo_q[k][ValidBitPos] && ((req_q.vaddr & imask_q[k]) == itag_q[k]);
      dpm[k] = dinfo_q[k][ValidBitPos] && ((req_q.vaddr & dmask_q[k]) == dtag_q[k]);
    end
  end

  // lowest-index priority select
  function automatic logic [IdxW-1:0] first(input logic [Entries-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int k = Entries - 1; k >= 0; k--) if (v[k]) r = IdxW'(k);
    return r;
  endfunction

  logic [IdxW-1:0] is_, ds, ips, dps;
  assign is_ = first(ihit);
  assign ds = first(dhit);
  assign ips = first(ipm);
  assign dps = first(dpm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Entries; k++) begin
        itag_q[k] <= '0; iphys_q[k] <= '0; imask_q[k] <= '0; iinfo_q[k] <= '0;
        dtag_q[k] <= '0; dphys_q[k] <= '0; dmask_q[k] <= '0; dinfo_q[k] <= '0;
      end
      rptr_q <= '0;
    end else if (cmd_i.exec) begin
      unique case (req_q.op)
        OP_ILOOKUP: begin
          if (ihit == '0 && req_q.fill_valid) begin
            itag_q[rptr_q] <= req_q.fill_tag;
            iphys_q[rptr_q] <= req_q.fill_phys;
            imask_q[rptr_q] <= req_q.fill_mask;
            iinfo_q[rptr_q] <= req_q.fill_info;
            rptr_q <= (rptr_q == IdxW'(Entries - 1)) ? '0 : rptr_q + 1'b1;
          end
        end
        OP_DLOOKUP: begin
          if (dhit != '0) begin
            for (int k = 1; k < Entries; k++) begin
              if (IdxW'(k) <= ds) begin
                dtag_q[k] <= dtag_q[k-1]; dphys_q[k] <= dphys_q[k-1];
                dmask_q[k] <= dmask_q[k-1]; dinfo_q[k] <= dinfo_q[k-1];
              end
            end
            dtag_q[0] <= dtag_q[ds]; dphys_q[0] <= dphys_q[ds];
            dmask_q[0] <= dmask_q[ds]; dinfo_q[0] <= dinfo_q[ds];
          end else if (req_q.fill_valid) begin
            for (int k = 1; k < Entries; k++) begin
              dtag_q[k] <= dtag_q[k-1]; dphys_q[k] <= dphys_q[k-1];
              dmask_q[k] <= dmask_q[k-1]; dinfo_q[k] <= dinfo_q[k-1];
            end
            dtag_q[0] <= req_q.fill_tag; dphys_q[0] <= req_q.fill_phys;
            dmask_q[0] <= req_q.fill_mask; dinfo_q[0] <= req_q.fill_info;
          end
        end
        OP_PURGE: begin
          if (ipm != '0) iinfo_q[ips][ValidBitPos] <= 1'b0;
          if (dpm != '0) dinfo_q[dps][ValidBitPos] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  rsp_t rsp_d;
  always_comb begin
    rsp_d = '0;
    unique case (req_q.op)
      OP_ILOOKUP: begin
        if (ihit != '0) begin
          rsp_d = '{1'b1, 1'b1, iphys_q[is_] | (req_q.vaddr & ~imask_q[is_]), iinfo_q[is_]};
        end else if (req_q.fill_valid) begin
          rsp_d = '{1'b1, 1'b0, req_q.fill_phys | (req_q.vaddr & ~req_q.fill_mask),
                    req_q.fill_info};
        end
      end
      OP_DLOOKUP: begin
        if (dhit != '0) begin
          rsp_d = '{1'b1, 1'b1, dphys_q[ds] | (req_q.vaddr & ~dmask_q[ds]), dinfo_q[ds]};
        end else if (req_q.fill_valid) begin
          rsp_d = '{1'b1, 1'b0, req_q.fill_phys | (req_q.vaddr & ~req_q.fill_mask),
                    req_q.fill_info};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.exec) rsp_q <= rsp_d;
  end
  assign rsp_o = rsp_q;
endmodule

[sv/smt_ctrl.sv]
// Controller: sequences capture, lookup and result handoff.
module smt_ctrl import smt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;
  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load = in_ready_o && in_valid_i;
  assign cmd_o.exec = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o) else $error("exec not followed by result");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmd_o.load) else $error("load while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule

[sv/split_micro_tlb.sv]
// Top level: split instruction/data micro TLB with stream ports.
// A transaction is captured at acceptance, matched and applied to the buffers
// on the next edge, and the result is offered from the cycle after that.
// One transaction is in flight at a time; the input is ready again the cycle
// after the result is taken. The match is fully associative over four entries
// per side; lowest matching entry wins. Data side keeps most recent use in
// slot 0; instruction side refills round robin. Purge clears the valid bit
// of the first match in both buffers and answers all zero.
module split_micro_tlb import smt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: vaddr[63:0], fill_valid[64], fill_tag[128:65], fill_phys[192:129],
  //        fill_mask[256:193], fill_info[272:257], zero pad
  input  logic [279:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: translated[0], local_hit[1], phys_addr[65:2], entry_info[81:66], pad
  output logic [87:0]  m_axis_tdata
);
  cmd_t cmd;
  req_t req;
  rsp_t rsp;

  assign req.op = s_axis_tuser;
  assign req.vaddr = s_axis_tdata[63:0];
  assign req.fill_valid = s_axis_tdata[64];
  assign req.fill_tag = s_axis_tdata[128:65];
  assign req.fill_phys = s_axis_tdata[192:129];
  assign req.fill_mask = s_axis_tdata[256:193];
  assign req.fill_info = s_axis_tdata[272:257];

  smt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd)
  );

  smt_datapath u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .req_i(req), .rsp_o(rsp));

  assign m_axis_tdata = {6'd0, rsp.entry_info, rsp.phys_addr, rsp.local_hit, rsp.translated};
endmodule

[verif/tb_top.sv]
// Testbench for the split micro TLB: directed and random lookups, fills and purges.
module tb_top;
  import smt_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [1:0]  OP_NONE = 2'd3;  // unused opcode, answers all zero

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [279:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [87:0]  m_axis_tdata;

  split_micro_tlb u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Shadow copy of both buffers
  logic [63:0] i_tag [Entries], i_phys [Entries], i_mask [Entries];
  logic [15:0] i_info [Entries];
  logic [63:0] d_tag [Entries], d_phys [Entries], d_mask [Entries];
  logic [15:0] d_info [Entries];
  int unsigned rr_slot;

  rsp_t expected_rsps [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;

  // Recently used pages, so random lookups mostly hit something real
  logic [63:0] page_tag [$], page_mask [$];

  function automatic int find_entry(input logic [63:0] tg[Entries],
                                    input logic [63:0] mk[Entries],
                                    input logic [15:0] inf[Entries],
                                    input logic [63:0] va);
    for (int k = 0; k < Entries; k++)
      if (inf[k][ValidBitPos] && ((va & mk[k]) == tg[k])) return k;
    return -1;
  endfunction

  function automatic rsp_t translate(input req_t rq);
    rsp_t r;
    int s;
    logic [63:0] cva;
    logic [63:0] ht, hp, hm;
    logic [15:0] hi;
    r = '0;
    cva = rq.vaddr & VaMask;
    case (rq.op)
      OP_ILOOKUP: begin
        s = find_entry(i_tag, i_mask, i_info, cva);
        if (s >= 0) begin
          r.translated = 1'b1; r.local_hit = 1'b1;
          r.phys_addr = i_phys[s] | (rq.vaddr & ~i_mask[s]);
          r.entry_info = i_info[s];
        end else if (rq.fill_valid) begin
          i_tag[rr_slot] = rq.fill_tag; i_phys[rr_slot] = rq.fill_phys;
          i_mask[rr_slot] = rq.fill_mask; i_info[rr_slot] = rq.fill_info;
          rr_slot = (rr_slot + 1) % Entries;
          r.translated = 1'b1;
          r.phys_addr = rq.fill_phys | (rq.vaddr & ~rq.fill_mask);
          r.entry_info = rq.fill_info;
        end
      end
      OP_DLOOKUP: begin
        s = find_entry(d_tag, d_mask, d_info, cva);
        if (s >= 0) begin
          ht = d_tag[s]; hp = d_phys[s]; hm = d_mask[s]; hi = d_info[s];
          r.local_hit = 1'b1;
        end else begin
          s = Entries - 1;
          ht = rq.fill_tag; hp = rq.fill_phys; hm = rq.fill_mask; hi = rq.fill_info;
        end
        if (r.local_hit || rq.fill_valid) begin
          // most recent use to slot 0, the rest move down
          for (int k = s; k > 0; k--) begin
            d_tag[k] = d_tag[k-1]; d_phys[k] = d_phys[k-1];
            d_mask[k] = d_mask[k-1]; d_info[k] = d_info[k-1];
          end
          d_tag[0] = ht; d_phys[0] = hp; d_mask[0] = hm; d_info[0] = hi;
          r.translated = 1'b1;
          r.phys_addr = hp | (rq.vaddr & ~hm);
          r.entry_info = hi;
        end
      end
      OP_PURGE: begin
        // purge compares the unmasked address
        s = find_entry(i_tag, i_mask, i_info, rq.vaddr);
        if (s >= 0) i_info[s][ValidBitPos] = 1'b0;
        s = find_entry(d_tag, d_mask, d_info, rq.vaddr);
        if (s >= 0) d_info[s][ValidBitPos] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one transaction with burst/gap pacing; changes at the falling edge
  task automatic send_req(input req_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.op;
    s_axis_tdata  <= {8'h0, rq.fill_info, rq.fill_mask, rq.fill_phys, rq.fill_tag,
                      rq.fill_valid, rq.vaddr};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_rsps.push_back(translate(rq));
    if (rq.op != OP_PURGE && rq.fill_valid) begin
      page_tag.push_back(rq.fill_tag); page_mask.push_back(rq.fill_mask);
      if (page_tag.size() > 12) begin
        void'(page_tag.pop_front()); void'(page_mask.pop_front());
      end
    end
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t fill_req(input logic [1:0] op, input logic [63:0] tg,
                                    input logic [63:0] mk, input logic [15:0] info);
    req_t rq;
    rq.op = op; rq.fill_valid = 1'b1;
    rq.fill_tag = tg; rq.fill_mask = mk; rq.fill_info = info;
    rq.fill_phys = rand64() & mk;
    rq.vaddr = tg | (rand64() & ~mk);
    return rq;
  endfunction

  // Directed: extremes, every opcode, total miss, fill without valid bit,
  // purge, round robin wrap
  task automatic test_directed();
    req_t rq;
    logic [63:0] pmask;
    pmask = 64'hFFFF_FFFF_FFFF_F000 & VaMask;
    rq = '0; rq.op = OP_ILOOKUP; send_req(rq);              // total miss
    rq = '0; rq.op = OP_DLOOKUP; rq.vaddr = '1; send_req(rq);
    rq = '0; rq.op = OP_NONE; rq.vaddr = '1; rq.fill_valid = 1'b1;
    rq.fill_tag = '1; rq.fill_phys = '1; rq.fill_mask = '1; rq.fill_info = '1;
    send_req(rq);
    for (int k = 0; k < 5; k++) begin                      // wrap past slot 3
      rq = fill_req(OP_ILOOKUP, (64'(k + 1) << 12), pmask, 16'h8000 | 16'(k));
      send_req(rq);
      rq = fill_req(OP_DLOOKUP, (64'(k + 1) << 12), pmask, 16'hFFFF);
      send_req(rq);
    end
    rq = fill_req(OP_ILOOKUP, 64'h3000, pmask, 16'h8000); rq.fill_valid = 1'b0;
    send_req(rq);                                          // local hit
    rq.op = OP_DLOOKUP; send_req(rq);
    rq = fill_req(OP_DLOOKUP, 64'h9000, pmask, 16'h7FFF);  // no valid bit
    send_req(rq);
    rq.fill_valid = 1'b0; send_req(rq);                    // still a miss
    rq = '0; rq.op = OP_PURGE; rq.vaddr = 64'h3ABC; send_req(rq);
    rq.op = OP_ILOOKUP; send_req(rq);
    rq.op = OP_DLOOKUP; send_req(rq);
    rq = fill_req(OP_ILOOKUP, '0, '0, 16'h8000); rq.vaddr = '1; // mask zero
    send_req(rq);
    rq.op = OP_PURGE; send_req(rq);
  endtask

  // Random: mostly lookups to recent pages, fills, some purges and noise
  task automatic test_random(input int unsigned n);
    req_t rq;
    int unsigned sel, p;
    logic [63:0] mk;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      mk = ({64{1'b1}} << $urandom_range(0, 30)) & VaMask;
      rq.op = ($urandom_range(0, 1) == 0) ? OP_ILOOKUP : OP_DLOOKUP;
      if (sel < 45 && page_tag.size() > 0) begin
        p = $urandom_range(0, page_tag.size() - 1);
        rq = fill_req(rq.op, page_tag[p], page_mask[p], 16'($urandom));
        rq.fill_valid = 1'($urandom);
        if ($urandom_range(0, 3) == 0) rq.vaddr[63:VaBits] = 12'($urandom);
      end else if (sel < 80) begin
        rq = fill_req(rq.op, rand64() & mk, mk, 16'($urandom) | 16'h8000);
        if ($urandom_range(0, 7) == 0) rq.fill_info[ValidBitPos] = 1'b0;
      end else if (sel < 90 && page_tag.size() > 0) begin
        p = $urandom_range(0, page_tag.size() - 1);
        rq = '0; rq.op = OP_PURGE;
        rq.vaddr = page_tag[p] | (rand64() & ~page_mask[p]);
      end else begin
        rq.vaddr = rand64(); rq.fill_valid = 1'($urandom);
        rq.fill_tag = rand64(); rq.fill_phys = rand64();
        rq.fill_mask = rand64(); rq.fill_info = 16'($urandom);
        rq.op = 2'($urandom);
      end
      send_req(rq);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ILOOKUP;
    mismatches = 0;
    burst_left = 0;
    rr_slot = 0;
    for (int k = 0; k < Entries; k++) begin
      i_tag[k] = '0; i_phys[k] = '0; i_mask[k] = '0; i_info[k] = '0;
      d_tag[k] = '0; d_phys[k] = '0; d_mask[k] = '0; d_info[k] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(680);
    s_axis_tvalid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Receiver stall pattern: long ready runs mixed with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (($urandom_range(0, 63) < 24)) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  // Result checker
  always @(posedge clk_i) begin
    rsp_t got, exp_rsp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[65:2], m_axis_tdata[81:66]};
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h", m_axis_tdata);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (got !== exp_rsp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp tr=%b lh=%b pa=%h info=%h, got tr=%b lh=%b pa=%h info=%h",
                     exp_rsp.translated, exp_rsp.local_hit, exp_rsp.phys_addr,
                     exp_rsp.entry_info, got.translated, got.local_hit,
                     got.phys_addr, got.entry_info);
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on either stream port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end else idle_cycles <= 0;
  end
endmodule
